/* src/lcu_pkg.sv */
// Shared types and constants for the longest dominance chain unit.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lcu_pkg;

  // Default capacity of the item set.
  localparam int MAX_ITEMS_DEF = 32;

  // Fixed field widths of the item and result streams.
  localparam int WEIGHT_W = 16;
  localparam int SMART_W  = 16;
  localparam int VALUE_W  = 6;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;

  // Result kinds carried on the output tuser bit.
  localparam logic KIND_LENGTH = 1'b0;
  localparam logic KIND_INDEX  = 1'b1;

  // One stored input item.
  typedef struct packed {
    logic [SMART_W-1:0]  smartness;
    logic [WEIGHT_W-1:0] weight;
  } item_t;

endpackage

`default_nettype wire

/* src/lcu_item_store.sv */
// Item memory of the longest dominance chain unit: weight and smartness per item.
// Depends on lcu_pkg for item_t. One write port, one registered read port.
`default_nettype none

module lcu_item_store
  import lcu_pkg::*;
#(
  parameter int DEPTH = MAX_ITEMS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire item_t         wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output item_t              rdata
);

  item_t mem [DEPTH];

  // Write port, used while the set is loaded.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/lcu_dp_table.sv */
// Chain table of the longest dominance chain unit: chain length and predecessor per item.
// Depends on lcu_pkg for MAX_ITEMS_DEF; one write port, one registered read port.
`default_nettype none

module lcu_dp_table
  import lcu_pkg::*;
#(
  parameter int DEPTH = MAX_ITEMS_DEF,
  parameter int LEN_W = 6,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [LEN_W-1:0] wlen,
  input  wire logic [AW-1:0]    wpred,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [LEN_W-1:0] rlen,
  output logic      [AW-1:0]    rpred
);

  logic [LEN_W+AW-1:0] mem [DEPTH];

  // A row is written once, when its scan over earlier items ends.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wlen, wpred};
    end
  end

  // Registered read; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      {rlen, rpred} <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/longest_dominance_chain_unit.sv */
// Top level of the longest dominance chain unit: sequencer, scan logic and result register.
// Depends on lcu_pkg, lcu_item_store and lcu_dp_table.
//
// Usage: items (weight, smartness) enter on the s_axis channel, one per cycle while
// s_axis_tready is high. The item with s_axis_tlast set closes the set; items beyond
// MAX_ITEMS are dropped, but a tlast on such an item still closes the set.
// After the closing item the block computes with s_axis_tready low; the comparisons
// of each item against the earlier ones run one after another, bound by the single
// read port of the item memory and of the chain table.
// Results then leave on m_axis: first the chain length (tuser = 0), then the member
// indices from the chain end back to its start (tuser = 1), tlast on the final one.
// Each index result goes through a chain table read state, then an output state.
// A stalled receiver holds the result register and the sequencer waits; input is
// taken again as soon as the final result sits in the result register.
// Reset empties the set and the result register; the memories need no clearing.
`default_nettype none

module longest_dominance_chain_unit
  import lcu_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] weight, [31:16] smartness
  input  wire logic                  s_axis_tlast,   // last_item
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [5:0] value, [7:6] zero
  output logic                       m_axis_tuser,   // kind
  output logic                       m_axis_tlast    // last_result
);

  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  localparam logic [2:0] ST_LOAD      = 3'd0;
  localparam logic [2:0] ST_ROW_RD    = 3'd1;
  localparam logic [2:0] ST_ROW_LD    = 3'd2;
  localparam logic [2:0] ST_SCAN      = 3'd3;
  localparam logic [2:0] ST_ROW_WR    = 3'd4;
  localparam logic [2:0] ST_EMIT_LEN  = 3'd5;
  localparam logic [2:0] ST_TRACE_RD  = 3'd6;
  localparam logic [2:0] ST_TRACE_OUT = 3'd7;

  logic [2:0]       state;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] col;
  logic [WEIGHT_W-1:0] row_weight;
  logic [SMART_W-1:0]  row_smart;
  logic [CNT_W-1:0] row_len;
  logic [IDX_W-1:0] row_pred;
  logic [CNT_W-1:0] best;
  logic [IDX_W-1:0] best_end;
  logic [IDX_W-1:0] cur;
  logic [CNT_W-1:0] steps;
  logic [VALUE_W-1:0] out_value;

  // Memory ports.
  logic             item_we;
  item_t            item_wdata;
  logic             item_re;
  logic [IDX_W-1:0] item_raddr;
  item_t            item_rdata;
  logic             dp_we;
  logic             dp_re;
  logic [IDX_W-1:0] dp_raddr;
  logic [CNT_W-1:0] dp_rlen;
  logic [IDX_W-1:0] dp_rpred;

  logic             in_accept;
  logic             has_room;
  logic             out_free;
  logic [IDX_W-1:0] scan_addr;
  logic             scan_issue;
  logic             hit;
  logic             last_row;
  logic             last_step;

  lcu_item_store #(.DEPTH(MAX_ITEMS)) u_items (
    .clk   (clk),
    .we    (item_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (item_wdata),
    .re    (item_re),
    .raddr (item_raddr),
    .rdata (item_rdata)
  );

  lcu_dp_table #(.DEPTH(MAX_ITEMS), .LEN_W(CNT_W)) u_table (
    .clk   (clk),
    .we    (dp_we),
    .waddr (row),
    .wlen  (row_len),
    .wpred (row_pred),
    .re    (dp_re),
    .raddr (dp_raddr),
    .rlen  (dp_rlen),
    .rpred (dp_rpred)
  );

  // Handshake and loading.
  assign s_axis_tready = (state == ST_LOAD);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign has_room      = (count < CNT_W'(MAX_ITEMS));
  assign item_we       = in_accept && has_room;
  assign item_wdata.weight    = s_axis_tdata[WEIGHT_W-1:0];
  assign item_wdata.smartness = s_axis_tdata[WEIGHT_W +: SMART_W];
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Read addressing: the row item first, then earlier items from the nearest downward.
  assign scan_addr  = (state == ST_ROW_LD) ? (row - IDX_W'(1)) : (col - IDX_W'(1));
  assign scan_issue = ((state == ST_ROW_LD) && (row != '0)) ||
                      ((state == ST_SCAN) && (col != '0));
  assign item_re    = (state == ST_ROW_RD) || scan_issue;
  assign item_raddr = (state == ST_ROW_RD) ? row : scan_addr;
  assign dp_re      = scan_issue || (state == ST_TRACE_RD);
  assign dp_raddr   = (state == ST_TRACE_RD) ? cur : scan_addr;
  assign dp_we      = (state == ST_ROW_WR);

  // An earlier item extends the row's chain only when it is strictly longer.
  assign hit = (row_weight > item_rdata.weight) &&
               (row_smart < item_rdata.smartness) &&
               (((CNT_W+1)'(dp_rlen) + (CNT_W+1)'(1)) > (CNT_W+1)'(row_len));

  assign last_row  = ((CNT_W'(row) + CNT_W'(1)) == count);
  assign last_step = ((steps + CNT_W'(1)) == best);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_accept) begin
            if (has_room) begin
              count <= count + CNT_W'(1);
            end
            if (s_axis_tlast) begin
              state <= ST_ROW_RD;
            end
          end
        end
        ST_ROW_RD: begin
          state <= ST_ROW_LD;
        end
        ST_ROW_LD: begin
          state <= (row == '0) ? ST_ROW_WR : ST_SCAN;
        end
        ST_SCAN: begin
          if (col == '0) begin
            state <= ST_ROW_WR;
          end
        end
        ST_ROW_WR: begin
          state <= last_row ? ST_EMIT_LEN : ST_ROW_RD;
        end
        ST_EMIT_LEN: begin
          if (out_free) begin
            state <= ST_TRACE_RD;
          end
        end
        ST_TRACE_RD: begin
          state <= ST_TRACE_OUT;
        end
        ST_TRACE_OUT: begin
          if (out_free) begin
            if (last_step) begin
              state <= ST_LOAD;
              count <= '0;
            end else begin
              state <= ST_TRACE_RD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Row scan and running maximum; payload registers, no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        row      <= '0;
        best     <= '0;
        best_end <= '0;
      end
      ST_ROW_LD: begin
        row_weight <= item_rdata.weight;
        row_smart  <= item_rdata.smartness;
        row_len    <= CNT_W'(1);
        row_pred   <= row;
        col        <= scan_addr;
      end
      ST_SCAN: begin
        if (hit) begin
          row_len  <= dp_rlen + CNT_W'(1);
          row_pred <= col;
        end
        col <= scan_addr;
      end
      ST_ROW_WR: begin
        if (row_len > best) begin
          best     <= row_len;
          best_end <= row;
        end
        row <= row + IDX_W'(1);
      end
      ST_EMIT_LEN: begin
        cur   <= best_end;
        steps <= '0;
      end
      ST_TRACE_OUT: begin
        if (out_free) begin
          cur   <= dp_rpred;
          steps <= steps + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Result register: loaded when free, cleared when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == ST_EMIT_LEN || state == ST_TRACE_OUT) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT_LEN && out_free) begin
      out_value    <= VALUE_W'(best);
      m_axis_tuser <= KIND_LENGTH;
      m_axis_tlast <= 1'b0;
    end else if (state == ST_TRACE_OUT && out_free) begin
      out_value    <= VALUE_W'(cur);
      m_axis_tuser <= KIND_INDEX;
      m_axis_tlast <= last_step;
    end
  end

  assign m_axis_tdata = OUT_DATA_W'(out_value);

endmodule

`default_nettype wire

/* src/lcu_checker.sv */
// Port-level checks for the longest dominance chain unit, bound to its top level.
// Depends on lcu_pkg for the field widths and result kinds.
`default_nettype none

module lcu_checker
  import lcu_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic                  s_axis_tlast,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                  m_axis_tuser,
  input wire logic                  m_axis_tlast
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
       $stable(m_axis_tlast)))
    else $error("stalled result changed");

  // The closing item of a set stops input while the chain is computed.
  a_close_stops_input: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input taken right after the closing item");

  // A length result never ends a run, since every chain has at least one member.
  a_length_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_LENGTH) |->
      (!m_axis_tlast && m_axis_tdata[VALUE_W-1:0] != '0 &&
       m_axis_tdata[VALUE_W-1:0] <= VALUE_W'(MAX_ITEMS)))
    else $error("bad length result");

  // Indices stay within the capacity.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_INDEX) |->
      (m_axis_tdata[VALUE_W-1:0] < VALUE_W'(MAX_ITEMS)))
    else $error("index result beyond capacity");

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind longest_dominance_chain_unit lcu_checker #(.MAX_ITEMS(MAX_ITEMS)) u_lcu_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

/* tb/longest_dominance_chain_unit_tb.sv */
// Self-checking testbench for the longest dominance chain unit.
// Depends on lcu_pkg and longest_dominance_chain_unit; drives item sets, predicts the chain.
`default_nettype none

module longest_dominance_chain_unit_tb;
  import lcu_pkg::*;

  localparam int CAP          = MAX_ITEMS_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 20;

  // One item waiting to be offered; drain asks the sender to wait for all results first.
  typedef struct {
    logic [WEIGHT_W-1:0] weight;
    logic [SMART_W-1:0]  smart;
    logic                last;
    logic                drain;
  } feed_item_t;

  // One result word as the block should emit it.
  typedef struct {
    logic               kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } chain_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [15:0] weight, [31:16] smartness
  logic                  s_axis_tlast = 1'b0; // last_item
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // [5:0] value, [7:6] zero
  logic                  m_axis_tuser;        // kind
  logic                  m_axis_tlast;        // last_result

  feed_item_t  items_pending[$];
  chain_word_t chain_words_due[$];
  feed_item_t  item_on_bus;

  // Predictor state: the loaded set of the current run.
  logic [WEIGHT_W-1:0] set_weight[CAP];
  logic [SMART_W-1:0]  set_smart[CAP];
  int                  set_count = 0;

  int fail_count = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  int hold_seen = 0;
  int cycle_count = 0;

  longest_dominance_chain_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // Idle length between items: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Load one accepted item; on the closing item run the chain search and queue its words.
  task automatic fold_item_into_chain(input feed_item_t it);
    int len[CAP];
    int prv[CAP];
    int n;
    int best;
    int best_end;
    int cur;
    chain_word_t w;
    if (set_count < CAP) begin
      set_weight[set_count] = it.weight;
      set_smart[set_count]  = it.smart;
      set_count++;
    end
    if (!it.last) return;
    n = set_count;
    // Longest chain ending at each item; nearest earlier item wins ties.
    for (int i = 0; i < n; i++) begin
      len[i] = 1;
      prv[i] = i;
      for (int j = i - 1; j >= 0; j--) begin
        if (set_weight[i] > set_weight[j] && set_smart[i] < set_smart[j] &&
            len[j] + 1 > len[i]) begin
          len[i] = len[j] + 1;
          prv[i] = j;
        end
      end
    end
    // The first item holding the maximum length ends the chain.
    best = 0;
    best_end = 0;
    for (int i = 0; i < n; i++) begin
      if (len[i] > best) begin
        best = len[i];
        best_end = i;
      end
    end
    w.kind  = KIND_LENGTH;
    w.value = VALUE_W'(best);
    w.last  = 1'b0;
    chain_words_due.push_back(w);
    cur = best_end;
    for (int k = 0; k < best; k++) begin
      w.kind  = KIND_INDEX;
      w.value = VALUE_W'(cur);
      w.last  = (k + 1 == best);
      chain_words_due.push_back(w);
      cur = prv[cur];
    end
    set_count = 0;
  endtask

  task automatic push_item(input int wt, input int sm, input bit lst, input bit drn);
    feed_item_t it;
    it.weight = WEIGHT_W'(wt);
    it.smart  = SMART_W'(sm);
    it.last   = lst;
    it.drain  = drn;
    items_pending.push_back(it);
  endtask

  // A set of n items closed by last; style picks narrow, full-range or chain-like values.
  task automatic queue_random_set(input int n, input int style, input bit drn);
    int wt;
    int sm;
    for (int i = 0; i < n; i++) begin
      case (style)
        0: begin
          wt = $urandom_range(0, 15);
          sm = $urandom_range(0, 15);
        end
        1: begin
          wt = $urandom_range(0, 65535);
          sm = $urandom_range(0, 65535);
        end
        default: begin
          wt = i * 1500 + $urandom_range(0, 4000);
          sm = 65535 - i * 1500 - $urandom_range(0, 4000);
        end
      endcase
      push_item(wt, sm, i == n - 1, drn && i == 0);
    end
  endtask

  // Sender: offers the next pending item whenever the bus slot is free.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        fold_item_into_chain(item_on_bus);
        send_gap = pick_gap();
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (items_pending.size() > 0 &&
                     (!items_pending[0].drain || chain_words_due.size() == 0)) begin
          item_on_bus = items_pending.pop_front();
          s_axis_tdata  <= {item_on_bus.smart, item_on_bus.weight};
          s_axis_tlast  <= item_on_bus.last;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started once partway through a long chain.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      hold_seen <= hold_seen + 1;
      if (hold_seen == HOLD_AFTER) hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver ready with random idling.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) recv_gap = pick_gap();
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Result checker: each accepted word against the oldest expected one.
  always @(posedge clk) begin
    chain_word_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (chain_words_due.size() == 0) begin
        $error("unexpected result item: kind %0d tdata %0d last %0d",
               m_axis_tuser, m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        w = chain_words_due.pop_front();
        if (m_axis_tuser !== w.kind) begin
          $error("kind mismatch: expected %0d, actual %0d", w.kind, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata !== {{(OUT_DATA_W - VALUE_W){1'b0}}, w.value}) begin
          $error("value mismatch: expected %0d, actual %0d", w.value, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== w.last) begin
          $error("last_result mismatch: expected %0d, actual %0d", w.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int queued;
    int n;
    int r;
    // Directed sets: field extremes, non-strict ties, nearest predecessor, first maximum.
    push_item(0, 0, 1'b1, 1'b0);
    push_item(65535, 65535, 1'b1, 1'b0);
    push_item(5, 10, 1'b0, 1'b0);
    push_item(5, 5, 1'b0, 1'b0);
    push_item(5, 1, 1'b1, 1'b0);
    push_item(1, 7, 1'b0, 1'b1);
    push_item(2, 7, 1'b1, 1'b0);
    push_item(10, 50, 1'b0, 1'b0);
    push_item(10, 50, 1'b0, 1'b0);
    push_item(20, 40, 1'b1, 1'b0);
    push_item(10, 50, 1'b0, 1'b0);
    push_item(20, 40, 1'b0, 1'b0);
    push_item(5, 60, 1'b0, 1'b0);
    push_item(15, 45, 1'b1, 1'b0);
    push_item(0, 65535, 1'b0, 1'b1);
    push_item(1, 65534, 1'b0, 1'b0);
    push_item(65534, 1, 1'b0, 1'b0);
    push_item(65535, 0, 1'b1, 1'b0);

    // A full-length chain, then a set that runs past capacity with last on a dropped item.
    for (int i = 0; i < CAP; i++) begin
      push_item(i * 2048 + $urandom_range(0, 2047),
                65535 - i * 2048 - $urandom_range(0, 2047), i == CAP - 1, 1'b0);
    end
    queue_random_set(CAP + $urandom_range(1, 4), 1, 1'b0);

    // Random sets, mostly small, each of narrow, full-range or chain-like content.
    queued = items_pending.size();
    while (queued < 120) begin
      r = $urandom_range(0, 99);
      if (r < 70) n = $urandom_range(1, 8);
      else if (r < 95) n = $urandom_range(9, 20);
      else n = $urandom_range(21, CAP);
      queue_random_set(n, $urandom_range(0, 2), $urandom_range(0, 4) == 0);
      queued += n;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (items_pending.size() > 0 || s_axis_tvalid || chain_words_due.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && chain_words_due.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
src/lcu_pkg.sv
src/lcu_item_store.sv
src/lcu_dp_table.sv
src/longest_dominance_chain_unit.sv
src/lcu_checker.sv
tb/longest_dominance_chain_unit_tb.sv
